// ===== src/iprc_pkg.sv =====
// Shared widths, limits, register codes and reset values for the PID rate controller.
`timescale 1ns / 1ps

package iprc_pkg;

  // Fixed-point format
  localparam int FRAC_BITS = 16;

  // Field widths
  localparam int RATE_W = 24;
  localparam int GAIN_W = 24;
  localparam int ERR_W  = RATE_W + 1;
  localparam int PDIF_W = ERR_W + 1;   // e - e1
  localparam int DDIF_W = ERR_W + 2;   // e - 2*e1 + e2
  localparam int ACC_W  = 40;
  localparam int IACC_W = FRAC_BITS + 4;  // holds +-5.0
  localparam int DRV_W  = FRAC_BITS + 5;  // holds +-10.0

  // Product and increment widths
  localparam int PP_W   = GAIN_W + PDIF_W;
  localparam int IP_W   = GAIN_W + ERR_W;
  localparam int DP_W   = GAIN_W + DDIF_W;
  localparam int PINC_W = PP_W - FRAC_BITS;
  localparam int IINC_W = IP_W - FRAC_BITS;
  localparam int DINC_W = DP_W - FRAC_BITS;
  localparam int PSUM_W = ((PINC_W > ACC_W) ? PINC_W : ACC_W) + 1;
  localparam int DSUM_W = ((DINC_W > ACC_W) ? DINC_W : ACC_W) + 1;
  localparam int ISUM_W = ((IINC_W > IACC_W) ? IINC_W : IACC_W) + 1;
  localparam int SUM_W  = ACC_W + 2;

  // Configuration port
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = GAIN_W;

  localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN = 2'd2;

  localparam logic signed [GAIN_W-1:0] PROP_GAIN_RST  = 24'sd393216;
  localparam logic signed [GAIN_W-1:0] INTEG_GAIN_RST = 24'sd655;
  localparam logic signed [GAIN_W-1:0] DERIV_GAIN_RST = 24'sd196608;

  // Saturation limits
  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  localparam logic signed [IACC_W-1:0] I_LIM   = IACC_W'(5 << FRAC_BITS);
  localparam logic signed [IACC_W-1:0] I_LIM_N = IACC_W'(-(5 << FRAC_BITS));

  localparam logic signed [DRV_W-1:0] O_LIM   = DRV_W'(10 << FRAC_BITS);
  localparam logic signed [DRV_W-1:0] O_LIM_N = DRV_W'(-(10 << FRAC_BITS));

endpackage

// ===== src/iprc_in_if.sv =====
// Input channel: one beat carries a measured and a target turn rate.
`timescale 1ns / 1ps

interface iprc_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [iprc_pkg::RATE_W-1:0]  measured_rate;
  logic signed [iprc_pkg::RATE_W-1:0]  target_rate;

  modport source (output valid, output measured_rate, output target_rate, input ready);
  modport sink   (input valid, input measured_rate, input target_rate, output ready);
endinterface

// ===== src/iprc_out_if.sv =====
// Result channel: one beat carries the drive rate and the clamp flag.
`timescale 1ns / 1ps

interface iprc_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [iprc_pkg::DRV_W-1:0]   drive_rate;
  logic                                clamped;

  modport source (output valid, output drive_rate, output clamped, input ready);
  modport sink   (input valid, input drive_rate, input clamped, output ready);
endinterface

// ===== src/incremental_pid_rate_controller_core.sv =====
// Top level: incremental PID rate controller, four-stage pipeline.
`timescale 1ns / 1ps

// Velocity-form PID on signed Q8.16 turn rates. Every input beat gives exactly one
// result beat, through the error, product, accumulator and output registers.
// A new beat is taken every cycle unless the result channel stalls: the stages are
// error register, gain products, accumulator update (P and D saturate at 40 bits,
// I is held to +-5.0) and the output sum clamped to +-10.0. Accumulator feedback
// allows one beat per cycle. Back-pressure on the result channel stalls the pipeline
// stage by stage; ready on the input channel falls only when every stage is full.
// Gains are written through the cfg_ port and should change only while idle.

module incremental_pid_rate_controller_core (
  input  logic                              clk,
  input  logic                              rst_n,
  iprc_in_if.sink                           in_if,
  iprc_out_if.source                        out_if,
  input  logic                              cfg_we,
  input  logic [iprc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [iprc_pkg::CFG_W-1:0]        cfg_data
);

  // Gain registers
  logic signed [iprc_pkg::GAIN_W-1:0] prop_gain_r, integ_gain_r, deriv_gain_r;

  // Stage valids and load enables
  logic err_v_r, prd_v_r, acc_v_r, out_v_r;
  logic ld_err, ld_prd, ld_acc, ld_out;
  logic mv_prd, mv_acc, mv_out;

  // Stage 1: error
  logic signed [iprc_pkg::ERR_W-1:0]  err_r, err_nxt;
  logic signed [iprc_pkg::ERR_W-1:0]  prev_err_r, prev_prev_err_r;

  // Stage 2: increments
  logic signed [iprc_pkg::PDIF_W-1:0] pdif;
  logic signed [iprc_pkg::DDIF_W-1:0] ddif;
  logic signed [iprc_pkg::PP_W-1:0]   pprod;
  logic signed [iprc_pkg::IP_W-1:0]   iprod;
  logic signed [iprc_pkg::DP_W-1:0]   dprod;
  logic signed [iprc_pkg::PINC_W-1:0] pinc_r;
  logic signed [iprc_pkg::IINC_W-1:0] iinc_r;
  logic signed [iprc_pkg::DINC_W-1:0] dinc_r;

  // Stage 3: accumulators
  logic signed [iprc_pkg::PSUM_W-1:0] psum;
  logic signed [iprc_pkg::ISUM_W-1:0] isum;
  logic signed [iprc_pkg::DSUM_W-1:0] dsum;
  logic signed [iprc_pkg::ACC_W-1:0]  prop_acc_r, prop_acc_nxt;
  logic signed [iprc_pkg::IACC_W-1:0] integ_acc_r, integ_acc_nxt;
  logic signed [iprc_pkg::ACC_W-1:0]  deriv_acc_r, deriv_acc_nxt;

  // Stage 4: output
  logic signed [iprc_pkg::SUM_W-1:0]  tot;
  logic signed [iprc_pkg::DRV_W-1:0]  drive_r, drive_nxt;
  logic                               clamped_r, clamped_nxt;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prop_gain_r  <= iprc_pkg::PROP_GAIN_RST;
      integ_gain_r <= iprc_pkg::INTEG_GAIN_RST;
      deriv_gain_r <= iprc_pkg::DERIV_GAIN_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        iprc_pkg::REG_PROP_GAIN:  prop_gain_r  <= $signed(cfg_data);
        iprc_pkg::REG_INTEG_GAIN: integ_gain_r <= $signed(cfg_data);
        iprc_pkg::REG_DERIV_GAIN: deriv_gain_r <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  // Pipeline flow control: a stage loads when empty or when it drains this cycle
  assign ld_out = !out_v_r || out_if.ready;
  assign ld_acc = !acc_v_r || ld_out;
  assign ld_prd = !prd_v_r || ld_acc;
  assign ld_err = !err_v_r || ld_prd;
  assign mv_out = acc_v_r && ld_out;
  assign mv_acc = prd_v_r && ld_acc;
  assign mv_prd = err_v_r && ld_prd;

  assign in_if.ready = ld_err;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      err_v_r <= 1'b0;
      prd_v_r <= 1'b0;
      acc_v_r <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (ld_err) err_v_r <= in_if.valid;
      if (ld_prd) prd_v_r <= err_v_r;
      if (ld_acc) acc_v_r <= prd_v_r;
      if (ld_out) out_v_r <= acc_v_r;
    end
  end

  // Stage 1: error of the accepted beat
  assign err_nxt = iprc_pkg::ERR_W'(in_if.target_rate) - iprc_pkg::ERR_W'(in_if.measured_rate);

  always_ff @(posedge clk) begin
    if (in_if.valid && ld_err) err_r <= err_nxt;
  end

  // Error history advances as each beat leaves stage 1
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_err_r      <= '0;
      prev_prev_err_r <= '0;
    end else if (mv_prd) begin
      prev_err_r      <= err_r;
      prev_prev_err_r <= prev_err_r;
    end
  end

  // Stage 2: differences, gain products, arithmetic shift by taking the upper bits
  always_comb begin
    pdif  = iprc_pkg::PDIF_W'(err_r) - iprc_pkg::PDIF_W'(prev_err_r);
    ddif  = iprc_pkg::DDIF_W'(err_r) - (iprc_pkg::DDIF_W'(prev_err_r) <<< 1)
          + iprc_pkg::DDIF_W'(prev_prev_err_r);
    pprod = prop_gain_r * pdif;
    iprod = integ_gain_r * err_r;
    dprod = deriv_gain_r * ddif;
  end

  always_ff @(posedge clk) begin
    if (mv_prd) begin
      pinc_r <= $signed(pprod[iprc_pkg::PP_W-1:iprc_pkg::FRAC_BITS]);
      iinc_r <= $signed(iprod[iprc_pkg::IP_W-1:iprc_pkg::FRAC_BITS]);
      dinc_r <= $signed(dprod[iprc_pkg::DP_W-1:iprc_pkg::FRAC_BITS]);
    end
  end

  // Stage 3: accumulate with saturation
  always_comb begin
    psum = iprc_pkg::PSUM_W'(prop_acc_r) + iprc_pkg::PSUM_W'(pinc_r);
    isum = iprc_pkg::ISUM_W'(integ_acc_r) + iprc_pkg::ISUM_W'(iinc_r);
    dsum = iprc_pkg::DSUM_W'(deriv_acc_r) + iprc_pkg::DSUM_W'(dinc_r);

    if (psum > iprc_pkg::ACC_MAX)      prop_acc_nxt = iprc_pkg::ACC_MAX;
    else if (psum < iprc_pkg::ACC_MIN) prop_acc_nxt = iprc_pkg::ACC_MIN;
    else                               prop_acc_nxt = psum[iprc_pkg::ACC_W-1:0];

    if (isum > iprc_pkg::I_LIM)        integ_acc_nxt = iprc_pkg::I_LIM;
    else if (isum < iprc_pkg::I_LIM_N) integ_acc_nxt = iprc_pkg::I_LIM_N;
    else                               integ_acc_nxt = isum[iprc_pkg::IACC_W-1:0];

    if (dsum > iprc_pkg::ACC_MAX)      deriv_acc_nxt = iprc_pkg::ACC_MAX;
    else if (dsum < iprc_pkg::ACC_MIN) deriv_acc_nxt = iprc_pkg::ACC_MIN;
    else                               deriv_acc_nxt = dsum[iprc_pkg::ACC_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prop_acc_r  <= '0;
      integ_acc_r <= '0;
      deriv_acc_r <= '0;
    end else if (mv_acc) begin
      prop_acc_r  <= prop_acc_nxt;
      integ_acc_r <= integ_acc_nxt;
      deriv_acc_r <= deriv_acc_nxt;
    end
  end

  // Stage 4: output sum and clamp
  always_comb begin
    tot = iprc_pkg::SUM_W'(prop_acc_r) + iprc_pkg::SUM_W'(integ_acc_r)
        + iprc_pkg::SUM_W'(deriv_acc_r);
    if (tot > iprc_pkg::O_LIM) begin
      drive_nxt   = iprc_pkg::O_LIM;
      clamped_nxt = 1'b1;
    end else if (tot < iprc_pkg::O_LIM_N) begin
      drive_nxt   = iprc_pkg::O_LIM_N;
      clamped_nxt = 1'b1;
    end else begin
      drive_nxt   = tot[iprc_pkg::DRV_W-1:0];
      clamped_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (mv_out) begin
      drive_r   <= drive_nxt;
      clamped_r <= clamped_nxt;
    end
  end

  assign out_if.valid      = out_v_r;
  assign out_if.drive_rate = drive_r;
  assign out_if.clamped    = clamped_r;

  // Checks
  a_drive_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> (drive_r <= iprc_pkg::O_LIM && drive_r >= iprc_pkg::O_LIM_N))
    else $error("drive rate beyond output limit");

  a_clamp_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && clamped_r) |-> (drive_r == iprc_pkg::O_LIM || drive_r == iprc_pkg::O_LIM_N))
    else $error("clamp flag set on an unclamped value");

  a_integ_range: assert property (@(posedge clk) disable iff (!rst_n)
    (integ_acc_r <= iprc_pkg::I_LIM && integ_acc_r >= iprc_pkg::I_LIM_N))
    else $error("integral term beyond its limit");

  a_prd_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (prd_v_r && !ld_acc) |=> (prd_v_r && $stable(pinc_r) && $stable(dinc_r)))
    else $error("stalled product stage lost its contents");

  a_err_history: assert property (@(posedge clk) disable iff (!rst_n)
    mv_prd |=> (prev_err_r == $past(err_r) && prev_prev_err_r == $past(prev_err_r)))
    else $error("error history out of step");

endmodule
